>>> rtl/ffba_pkg.sv
// shared types, codes and widths for the first-fit block allocator
package ffba_pkg;

    // default sizes
    localparam int DEF_TABLE_ENTRIES = 16;
    localparam int DEF_ADDRESS_BITS  = 16;

    // fixed field widths
    localparam int FIELD_BITS = 16;
    localparam int REQ_BITS   = 32;
    localparam int HEAP_BITS  = 17;
    localparam int COUNT_BITS = 5;

    // heap limit after reset
    localparam logic [HEAP_BITS-1:0] HEAP_LIMIT_RESET = 17'h10000;

    // operations
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // error codes
    localparam logic [1:0] ERR_OK         = 2'd0;
    localparam logic [1:0] ERR_NO_MEMORY  = 2'd1;
    localparam logic [1:0] ERR_TABLE_FULL = 2'd2;
    localparam logic [1:0] ERR_NOT_FOUND  = 2'd3;

    // lookup word handed from cell to cell, newest entry first
    typedef struct packed {
        logic                  valid;
        logic                  op;
        logic [REQ_BITS-1:0]   request;
        logic [FIELD_BITS-1:0] address;
        logic                  found;
        logic                  was_used;
        logic [HEAP_BITS-1:0]  base;
    } ffba_query_t;

    // append of a new entry into one cell
    typedef struct packed {
        logic                 en;
        logic [HEAP_BITS-1:0] base;
        logic [HEAP_BITS-1:0] size;
    } ffba_write_t;

endpackage

>>> rtl/first_fit_block_allocator_core.sv
// first-fit block allocator: sequencer, heap bookkeeping and the chain of entry cells
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------------------
//  command   | start / busy         | cmd, element_size, element_count, address
//  result    | done (one-cycle)     | block_address, error_code, free_blocks, used_blocks
//  config    | heap_limit_wr        | heap_limit
//
//  an item goes from accept to done through the multiply, the launch of the lookup, the
//  walk of the lookup word along the chain of cells from the newest entry to the oldest,
//  and the table update and result
//  busy is high from the accept until the result cycle; a new word may start then
//  reset clears the table to empty, the heap top to zero and the limit to 65536
//  results cannot be held off; done marks the single cycle they are valid
module first_fit_block_allocator_core #(
    parameter int TABLE_ENTRIES = ffba_pkg::DEF_TABLE_ENTRIES,
    parameter int ADDRESS_BITS  = ffba_pkg::DEF_ADDRESS_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cmd,
    input  logic [ffba_pkg::FIELD_BITS-1:0]    element_size,
    input  logic [ffba_pkg::FIELD_BITS-1:0]    element_count,
    input  logic [ffba_pkg::FIELD_BITS-1:0]    address,
    output logic                               done,
    output logic [ffba_pkg::FIELD_BITS-1:0]    block_address,
    output logic [1:0]                         error_code,
    output logic [ffba_pkg::COUNT_BITS-1:0]    free_blocks,
    output logic [ffba_pkg::COUNT_BITS-1:0]    used_blocks,
    input  logic                               heap_limit_wr,
    input  logic [ffba_pkg::HEAP_BITS-1:0]     heap_limit
);
    import ffba_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CMP_W = 34;
    localparam logic [CMP_W-1:0] SPAN = CMP_W'(1) << ADDRESS_BITS;
    localparam logic [FIELD_BITS-1:0] ADDR_MASK = (ADDRESS_BITS >= FIELD_BITS) ?
        {FIELD_BITS{1'b1}} : FIELD_BITS'((CMP_W'(1) << ADDRESS_BITS) - CMP_W'(1));
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_MUL    = 2'd1;
    localparam logic [1:0] S_LAUNCH = 2'd2;
    localparam logic [1:0] S_SCAN   = 2'd3;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [HEAP_BITS-1:0]  limit_reg;
    logic                  op_reg;
    logic [FIELD_BITS-1:0] esize_reg;
    logic [FIELD_BITS-1:0] ecount_reg;
    logic [FIELD_BITS-1:0] addr_reg;
    logic [REQ_BITS-1:0]   request_reg;
    logic                  no_mem_reg;
    logic [HEAP_BITS-1:0]  heap_top_reg;
    logic [HEAP_BITS-1:0]  heap_top_next;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [CNT_W-1:0]      free_total_reg;
    logic [CNT_W-1:0]      free_total_next;
    logic [CNT_W-1:0]      used_total_reg;
    logic [CNT_W-1:0]      used_total_next;
    logic                  done_reg;
    logic [FIELD_BITS-1:0] block_address_reg;
    logic [FIELD_BITS-1:0] block_address_next;
    logic [1:0]            error_code_reg;
    logic [1:0]            error_code_next;
    logic [COUNT_BITS-1:0] free_blocks_reg;
    logic [COUNT_BITS-1:0] used_blocks_reg;
    logic [CMP_W-1:0]      eff_limit;
    logic [CMP_W-1:0]      heap_end;
    logic                  no_mem_next;
    logic                  accept;
    logic                  finish;
    ffba_query_t           launch;
    ffba_query_t           link [TABLE_ENTRIES+1];
    ffba_query_t           result;
    ffba_write_t           wr;

    assign accept = start && !busy;
    assign busy   = state_reg != S_IDLE;
    assign result = link[0];
    assign finish = (state_reg == S_SCAN) && result.valid;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:    state_next = S_LAUNCH;
            S_LAUNCH: state_next = S_SCAN;
            S_SCAN:
            begin
                if (result.valid)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // heap test: top must be a valid address and top plus request within the limit
    assign eff_limit   = (CMP_W'(limit_reg) < SPAN) ? CMP_W'(limit_reg) : SPAN;
    assign heap_end    = CMP_W'(heap_top_reg) + CMP_W'(request_reg);
    assign no_mem_next = (CMP_W'(heap_top_reg) >= SPAN) || (heap_end > eff_limit);

    // lookup word entering the newest cell
    always_comb
    begin
        launch          = '0;
        launch.valid    = state_reg == S_LAUNCH;
        launch.op       = op_reg;
        launch.request  = request_reg;
        launch.address  = addr_reg;
    end

    assign link[TABLE_ENTRIES] = launch;

    // chain of entry cells, newest index first
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            ffba_cell #(
                .TABLE_ENTRIES (TABLE_ENTRIES),
                .INDEX         (gi)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .entry_count (count_reg),
                .wr          (wr),
                .wr_index    (count_reg[IDX_W-1:0]),
                .q_in        (link[gi+1]),
                .q_out       (link[gi])
            );
        end
    endgenerate

    // outcome of the lookup and table bookkeeping
    always_comb
    begin
        wr                 = '0;
        wr.base            = heap_top_reg;
        wr.size            = request_reg[HEAP_BITS-1:0];
        heap_top_next      = heap_top_reg;
        count_next         = count_reg;
        free_total_next    = free_total_reg;
        used_total_next    = used_total_reg;
        block_address_next = '0;
        error_code_next    = ERR_OK;
        if (op_reg == OP_ALLOC)
        begin
            if (result.found)
            begin
                block_address_next = result.base[FIELD_BITS-1:0];
                free_total_next    = free_total_reg - CNT_W'(1);
                used_total_next    = used_total_reg + CNT_W'(1);
            end
            else if (no_mem_reg)
            begin
                error_code_next = ERR_NO_MEMORY;
            end
            else if (count_reg == FULL_COUNT)
            begin
                error_code_next = ERR_TABLE_FULL;
            end
            else
            begin
                wr.en              = finish;
                block_address_next = heap_top_reg[FIELD_BITS-1:0];
                heap_top_next      = heap_top_reg + request_reg[HEAP_BITS-1:0];
                count_next         = count_reg + CNT_W'(1);
                used_total_next    = used_total_reg + CNT_W'(1);
            end
        end
        else
        begin
            block_address_next = addr_reg & ADDR_MASK;
            if (!result.found)
            begin
                error_code_next = ERR_NOT_FOUND;
            end
            else if (result.was_used)
            begin
                free_total_next = free_total_reg + CNT_W'(1);
                used_total_next = used_total_reg - CNT_W'(1);
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            limit_reg      <= HEAP_LIMIT_RESET;
            heap_top_reg   <= '0;
            count_reg      <= '0;
            free_total_reg <= '0;
            used_total_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= finish;
            if (heap_limit_wr)
            begin
                limit_reg <= heap_limit;
            end
            if (finish)
            begin
                heap_top_reg   <= heap_top_next;
                count_reg      <= count_next;
                free_total_reg <= free_total_next;
                used_total_reg <= used_total_next;
            end
        end
    end

    // operands, product and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg     <= cmd;
            esize_reg  <= element_size;
            ecount_reg <= element_count;
            addr_reg   <= address;
        end
        if (state_reg == S_MUL)
        begin
            request_reg <= REQ_BITS'(esize_reg) * REQ_BITS'(ecount_reg);
        end
        if (state_reg == S_LAUNCH)
        begin
            no_mem_reg <= no_mem_next;
        end
        if (finish)
        begin
            block_address_reg <= block_address_next;
            error_code_reg    <= error_code_next;
            free_blocks_reg   <= COUNT_BITS'(free_total_next);
            used_blocks_reg   <= COUNT_BITS'(used_total_next);
        end
    end

    assign done          = done_reg;
    assign block_address = block_address_reg;
    assign error_code    = error_code_reg;
    assign free_blocks   = free_blocks_reg;
    assign used_blocks   = used_blocks_reg;

endmodule

>>> rtl/ffba_cell.sv
// one table entry of the allocator chain with its lookup stage
module ffba_cell #(
    parameter int TABLE_ENTRIES = ffba_pkg::DEF_TABLE_ENTRIES,
    parameter int INDEX         = 0,
    localparam int CNT_W        = $clog2(TABLE_ENTRIES + 1),
    localparam int IDX_W        = $clog2(TABLE_ENTRIES)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CNT_W-1:0]      entry_count,
    input  ffba_pkg::ffba_write_t wr,
    input  logic [IDX_W-1:0]      wr_index,
    input  ffba_pkg::ffba_query_t q_in,
    output ffba_pkg::ffba_query_t q_out
);
    import ffba_pkg::*;

    logic [HEAP_BITS-1:0] base_reg;
    logic [HEAP_BITS-1:0] size_reg;
    logic                 used_reg;
    logic                 used_next;
    logic                 out_valid_reg;
    ffba_query_t          q_reg;
    ffba_query_t          q_next;
    logic                 live;
    logic                 fits;
    logic                 base_hit;
    logic                 hit;
    logic                 wr_here;

    // entry is part of the table
    assign live    = CNT_W'(INDEX) < entry_count;
    assign wr_here = wr.en && (wr_index == IDX_W'(INDEX));

    // first free block that is big enough, or newest base match
    assign fits     = !used_reg && (REQ_BITS'(size_reg) >= q_in.request);
    assign base_hit = base_reg == HEAP_BITS'(q_in.address);
    assign hit      = q_in.valid && !q_in.found && live &&
                      ((q_in.op == OP_ALLOC) ? fits : base_hit);

    // word passed on to the older neighbor
    always_comb
    begin
        q_next = q_in;
        if (hit)
        begin
            q_next.found    = 1'b1;
            q_next.was_used = used_reg;
            q_next.base     = base_reg;
        end
    end

    // used flag: taken by allocate, cleared by free, set on append
    always_comb
    begin
        used_next = used_reg;
        if (hit)
        begin
            used_next = (q_in.op == OP_ALLOC);
        end
        if (wr_here)
        begin
            used_next = 1'b1;
        end
    end

    // control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            out_valid_reg <= q_in.valid;
        end
    end

    // entry payload and stage payload
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        if (wr_here)
        begin
            base_reg <= wr.base;
            size_reg <= wr.size;
        end
    end

    always_comb
    begin
        q_out       = q_reg;
        q_out.valid = out_valid_reg;
    end

endmodule

>>> rtl/ffba_checker.sv
// port-level checks for the allocator core and their binding
module ffba_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic                            busy,
    input logic                            done,
    input logic [ffba_pkg::FIELD_BITS-1:0] block_address,
    input logic [1:0]                      error_code
);
    import ffba_pkg::*;

    // result arrives only once the block has gone idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted word makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // the end of every item gives exactly one result
    a_fell_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("item finished without a result");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // failed allocate grants no address
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (error_code == ERR_NO_MEMORY || error_code == ERR_TABLE_FULL))
            |-> (block_address == '0))
        else $error("failed allocate reported an address");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .block_address (block_address),
    .error_code    (error_code)
);

>>> verif/first_fit_block_allocator_checker.sv
// checker for the first-fit block allocator: predicts every result word and compares it
module first_fit_block_allocator_checker
    import ffba_pkg::*;
#(
    parameter int TABLE_ENTRIES = DEF_TABLE_ENTRIES,
    parameter int ADDRESS_BITS  = DEF_ADDRESS_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic                  cmd,
    input  logic [FIELD_BITS-1:0] element_size,
    input  logic [FIELD_BITS-1:0] element_count,
    input  logic [FIELD_BITS-1:0] address,
    input  logic                  done,
    input  logic [FIELD_BITS-1:0] block_address,
    input  logic [1:0]            error_code,
    input  logic [COUNT_BITS-1:0] free_blocks,
    input  logic [COUNT_BITS-1:0] used_blocks,
    input  logic                  heap_limit_wr,
    input  logic [HEAP_BITS-1:0]  heap_limit,
    input  logic                  end_of_test,
    output int                    pending_words,
    output int                    mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [33:0] ADDR_SPAN = 34'd1 << ADDRESS_BITS;

    typedef struct packed {
        logic [FIELD_BITS-1:0] block_addr;
        logic [1:0]            err;
        logic [COUNT_BITS-1:0] free_cnt;
        logic [COUNT_BITS-1:0] used_cnt;
    } alloc_report_t;

    // shadow copy of the block table, heap pointer and limit
    logic [HEAP_BITS-1:0] blk_base [TABLE_ENTRIES];
    logic [HEAP_BITS-1:0] blk_size [TABLE_ENTRIES];
    logic                 blk_used [TABLE_ENTRIES];
    int                   blk_count;
    logic [HEAP_BITS-1:0] heap_top;
    logic [HEAP_BITS-1:0] limit_copy;

    // result words still owed by the block, oldest first
    alloc_report_t report_q[$];

    // apply one command word to the shadow table and return the result it yields
    function automatic alloc_report_t apply_word(input logic op,
                                                 input logic [FIELD_BITS-1:0] esize,
                                                 input logic [FIELD_BITS-1:0] ecount,
                                                 input logic [FIELD_BITS-1:0] addr);
        alloc_report_t       rep;
        logic [REQ_BITS-1:0] request;
        logic [33:0]         eff_limit;
        logic                hit;
        int                  i;
        rep = '0;
        rep.err = ERR_OK;
        hit = 1'b0;
        if (op == OP_ALLOC) begin
            request = REQ_BITS'(esize) * REQ_BITS'(ecount);
            // first fit from the newest entry, block taken whole
            for (i = blk_count - 1; i >= 0; i--) begin
                if (!hit && !blk_used[i] && 34'(blk_size[i]) >= 34'(request)) begin
                    blk_used[i] = 1'b1;
                    rep.block_addr = blk_base[i][FIELD_BITS-1:0];
                    hit = 1'b1;
                end
            end
            // nothing fits: grow the heap, checked before the table
            if (!hit) begin
                eff_limit = (34'(limit_copy) < ADDR_SPAN) ? 34'(limit_copy) : ADDR_SPAN;
                if (34'(heap_top) >= ADDR_SPAN || 34'(heap_top) + 34'(request) > eff_limit)
                    rep.err = ERR_NO_MEMORY;
                else if (blk_count >= TABLE_ENTRIES)
                    rep.err = ERR_TABLE_FULL;
                else begin
                    blk_base[blk_count] = heap_top;
                    blk_size[blk_count] = request[HEAP_BITS-1:0];
                    blk_used[blk_count] = 1'b1;
                    blk_count = blk_count + 1;
                    rep.block_addr = heap_top[FIELD_BITS-1:0];
                    heap_top = heap_top + request[HEAP_BITS-1:0];
                end
            end
        end else begin
            // newest entry with a matching base is released
            rep.block_addr = addr;
            rep.err = ERR_NOT_FOUND;
            for (i = blk_count - 1; i >= 0; i--) begin
                if (!hit && blk_base[i] == HEAP_BITS'(addr)) begin
                    blk_used[i] = 1'b0;
                    rep.err = ERR_OK;
                    hit = 1'b1;
                end
            end
        end
        // occupancy after the word
        for (i = 0; i < blk_count; i++) begin
            if (blk_used[i])
                rep.used_cnt = rep.used_cnt + 1'b1;
            else
                rep.free_cnt = rep.free_cnt + 1'b1;
        end
        return rep;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // track config, predict on accept, compare on result
    always @(posedge clk or negedge rst_n) begin
        alloc_report_t want;
        if (!rst_n) begin
            for (int k = 0; k < TABLE_ENTRIES; k++) begin
                blk_base[k] = '0;
                blk_size[k] = '0;
                blk_used[k] = 1'b0;
            end
            blk_count = 0;
            heap_top = '0;
            limit_copy = HEAP_LIMIT_RESET;
            report_q.delete();
            mismatch_count = 0;
            pending_words <= 0;
        end else begin
            if (heap_limit_wr)
                limit_copy = heap_limit;
            if (done) begin
                if (report_q.size() == 0) begin
                    $display("%0t result word with none expected: actual addr %0d err %0d free %0d used %0d",
                             $time, block_address, error_code, free_blocks, used_blocks);
                    mismatch_count++;
                end else begin
                    want = report_q.pop_front();
                    check_field("block_address", want.block_addr, block_address);
                    check_field("error_code", want.err, error_code);
                    check_field("free_blocks", want.free_cnt, free_blocks);
                    check_field("used_blocks", want.used_cnt, used_blocks);
                end
            end
            if (start && !busy)
                report_q.push_back(apply_word(cmd, element_size, element_count, address));
            if (end_of_test && report_q.size() != 0) begin
                $display("%0t %0d result words never came, first expected addr %0d err %0d",
                         $time, report_q.size(), report_q[0].block_addr, report_q[0].err);
                mismatch_count += report_q.size();
                report_q.delete();
            end
            pending_words <= report_q.size();
        end
    end

endmodule

>>> verif/first_fit_block_allocator_core_tb.sv
// testbench top for the first-fit block allocator: reset, stimulus and verdict
module first_fit_block_allocator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffba_pkg::*;

    localparam int SETTLE_CYCLES = DEF_TABLE_ENTRIES + 8;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_WORDS   = 232;
    localparam int FILL_WORDS    = 12;

    // table fill: products 60190,1,2,4,8,0,16,32,64,100,1000,4096 end the heap at 65535
    localparam logic [FIELD_BITS-1:0] FILL_SIZE [FILL_WORDS] = '{
        16'd60190, 16'd1, 16'd1, 16'd2, 16'd4, 16'hFFFF,
        16'd4, 16'd8, 16'd2, 16'd10, 16'd8, 16'd64};
    localparam logic [FIELD_BITS-1:0] FILL_COUNT [FILL_WORDS] = '{
        16'd1, 16'd1, 16'd2, 16'd2, 16'd2, 16'd0,
        16'd4, 16'd4, 16'd32, 16'd10, 16'd125, 16'd64};

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  cmd;
    logic [FIELD_BITS-1:0] element_size;
    logic [FIELD_BITS-1:0] element_count;
    logic [FIELD_BITS-1:0] address;
    logic                  done;
    logic [FIELD_BITS-1:0] block_address;
    logic [1:0]            error_code;
    logic [COUNT_BITS-1:0] free_blocks;
    logic [COUNT_BITS-1:0] used_blocks;
    logic                  heap_limit_wr;
    logic [HEAP_BITS-1:0]  heap_limit;
    logic                  end_of_test;
    int                    pending_words;
    int                    mismatch_count;

    logic [FIELD_BITS-1:0] known_bases[$];
    logic [HEAP_BITS-1:0]  phase_limits [RANDOM_PHASES];

    first_fit_block_allocator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cmd           (cmd),
        .element_size  (element_size),
        .element_count (element_count),
        .address       (address),
        .done          (done),
        .block_address (block_address),
        .error_code    (error_code),
        .free_blocks   (free_blocks),
        .used_blocks   (used_blocks),
        .heap_limit_wr (heap_limit_wr),
        .heap_limit    (heap_limit)
    );

    first_fit_block_allocator_checker alloc_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .element_size   (element_size),
        .element_count  (element_count),
        .address        (address),
        .done           (done),
        .block_address  (block_address),
        .error_code     (error_code),
        .free_blocks    (free_blocks),
        .used_blocks    (used_blocks),
        .heap_limit_wr  (heap_limit_wr),
        .heap_limit     (heap_limit),
        .end_of_test    (end_of_test),
        .pending_words  (pending_words),
        .mismatch_count (mismatch_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // remember bases the block handed out so most frees hit live entries
    always @(posedge clk)
    begin
        bit seen;
        if (rst_n && done && error_code == ERR_OK) begin
            seen = 1'b0;
            foreach (known_bases[k])
                if (known_bases[k] == block_address)
                    seen = 1'b1;
            if (!seen)
                known_bases.push_back(block_address);
        end
    end

    // present one command word and hold it until accepted
    task automatic send_word(input logic op, input logic [FIELD_BITS-1:0] esize,
                             input logic [FIELD_BITS-1:0] ecount,
                             input logic [FIELD_BITS-1:0] addr);
        start <= 1'b1;
        cmd <= op;
        element_size <= esize;
        element_count <= ecount;
        address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic idle_for(input int cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // hold off until every owed result word is back and the block has settled
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input logic [HEAP_BITS-1:0] value);
        heap_limit_wr <= 1'b1;
        heap_limit <= value;
        @(posedge clk);
        heap_limit_wr <= 1'b0;
    endtask

    // mostly frees of live bases and small requests so blocks keep cycling
    task automatic send_random_word();
        int unsigned           pick;
        logic                  op;
        logic [FIELD_BITS-1:0] esize;
        logic [FIELD_BITS-1:0] ecount;
        logic [FIELD_BITS-1:0] addr;
        pick = $urandom_range(99);
        esize = FIELD_BITS'($urandom);
        ecount = FIELD_BITS'($urandom);
        addr = FIELD_BITS'($urandom);
        op = OP_ALLOC;
        if (pick < 45) begin
            op = OP_FREE;
            if (known_bases.size() > 0)
                addr = known_bases[$urandom_range(known_bases.size() - 1)];
        end else if (pick < 55) begin
            op = OP_FREE;
        end else if (pick < 82) begin
            esize = FIELD_BITS'($urandom_range(64));
            ecount = FIELD_BITS'($urandom_range(8));
        end else if (pick < 93) begin
            esize = FIELD_BITS'($urandom_range(4096));
            ecount = FIELD_BITS'($urandom_range(3));
        end
        send_word(op, esize, ecount, addr);
    endtask

    // stimulus and verdict
    initial
    begin
        int left;
        int burst;
        int waited;
        rst_n <= 1'b0;
        start <= 1'b0;
        cmd <= OP_ALLOC;
        element_size <= '0;
        element_count <= '0;
        address <= '0;
        heap_limit_wr <= 1'b0;
        heap_limit <= HEAP_LIMIT_RESET;
        end_of_test <= 1'b0;
        phase_limits = '{17'h10000, 17'd0, 17'hFFFF, 17'h1FFFF, 17'd1, 17'h10000, 17'd0};
        phase_limits[RANDOM_PHASES-1] = HEAP_BITS'($urandom_range(17'h1FFFF));
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero-byte entry, then a second entry on the same base
        send_word(OP_ALLOC, 16'd0, 16'd0, 16'hFFFF);
        send_word(OP_ALLOC, 16'd16, 16'd1, 16'd0);
        // free hits the newest of the two, then free it again while already free
        send_word(OP_FREE, 16'hFFFF, 16'hFFFF, 16'd0);
        send_word(OP_FREE, 16'd0, 16'd0, 16'd0);
        // address that was never handed out
        send_word(OP_FREE, 16'd0, 16'd0, 16'hFFFF);
        // largest product, far past the limit
        send_word(OP_ALLOC, 16'hFFFF, 16'hFFFF, 16'd0);
        // zero bytes take any free block
        send_word(OP_ALLOC, 16'd1, 16'd0, 16'd0);
        // fresh entry, released, then reused whole by a smaller request
        send_word(OP_ALLOC, 16'd2, 16'd3, 16'd0);
        send_word(OP_FREE, 16'd0, 16'd0, 16'd16);
        send_word(OP_ALLOC, 16'd4, 16'd1, 16'd0);

        // limit equal to the heap top: one byte too many, zero bytes still fit
        drain_results();
        write_limit(17'd22);
        send_word(OP_ALLOC, 16'd1, 16'd1, 16'd0);
        send_word(OP_ALLOC, 16'd0, 16'd7, 16'd0);

        // widest limit; fill the table, heap top ends one byte short of the span
        drain_results();
        write_limit(17'h1FFFF);
        for (int k = 0; k < FILL_WORDS; k++)
            send_word(OP_ALLOC, FILL_SIZE[k], FILL_COUNT[k], 16'd0);
        // one byte fits the heap but the table is full, two bytes do not fit the heap
        send_word(OP_ALLOC, 16'd1, 16'd1, 16'd0);
        send_word(OP_ALLOC, 16'd1, 16'd2, 16'd0);

        // random phases, each under its own limit, sent in bursts with gaps
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            write_limit(phase_limits[p]);
            left = PHASE_WORDS;
            while (left > 0) begin
                burst = $urandom_range(1, 24);
                while (burst > 0 && left > 0) begin
                    send_random_word();
                    burst--;
                    left--;
                end
                idle_for(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40));
            end
        end

        // wait for the last words, then let the checker sweep leftovers
        start <= 1'b0;
        waited = 0;
        do begin
            @(posedge clk);
            waited++;
        end while (pending_words != 0 && waited < 1000);
        repeat (SETTLE_CYCLES) @(posedge clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/ffba_pkg.sv
rtl/ffba_cell.sv
rtl/first_fit_block_allocator_core.sv
rtl/ffba_checker.sv
verif/first_fit_block_allocator_checker.sv
verif/first_fit_block_allocator_core_tb.sv
